// ----- hw/rtl/bmc_interval_decoder_assert.svh -----
// Assertion macros used by the decoder port checker (bmcd_chk).
// Both sample on clk and are disabled while rst is high.
`ifndef BMC_INTERVAL_DECODER_ASSERT_SVH
`define BMC_INTERVAL_DECODER_ASSERT_SVH

// Same-cycle implication.
`define BMCD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bmcd: same-cycle check failed");

// Next-cycle implication.
`define BMCD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bmcd: next-cycle check failed");

`endif

// ----- hw/rtl/bmcd_pkg.sv -----
// ----------------------------------------------------------------------------
// bmcd_pkg
// Types and constants for the biphase-mark interval decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package bmcd_pkg;

  localparam int MAX_BITS      = 1024;
  localparam int PREAMBLE_BITS = 64;
  localparam int SYMBOL_BITS   = 5;

  localparam int IVL_W     = 8;
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 2;
  localparam int SYM_W     = SYMBOL_BITS;
  localparam int STATUS_W  = 2;
  localparam int TOTAL_W   = $clog2(MAX_BITS + 1);
  localparam int FILL_W    = $clog2(SYMBOL_BITS);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_W-1:0] FULL_MIN_RST = 8'd20;
  localparam logic [CFG_W-1:0] FULL_MAX_RST = 8'd40;
  localparam logic [CFG_W-1:0] HALF_MIN_RST = 8'd8;
  localparam logic [CFG_W-1:0] HALF_MAX_RST = 8'd19;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FULL_MIN = 2'd0,
    REG_FULL_MAX = 2'd1,
    REG_HALF_MIN = 2'd2,
    REG_HALF_MAX = 2'd3
  } cfg_reg_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 2'd0,
    ST_NO_PREAMBLE = 2'd1,
    ST_TOO_SHORT   = 2'd2
  } status_t;

  // Classified event passed from front to back.
  typedef struct packed {
    logic bit_valid;
    logic bit_value;
    logic eop;
  } evt_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bmcd_if.sv -----
// ----------------------------------------------------------------------------
// bmcd_in_if / bmcd_out_if
// Valid/ready channels for interval items and decoded results.
// ----------------------------------------------------------------------------
`default_nettype none

interface bmcd_in_if;
  logic                          valid;
  logic                          ready;
  logic [bmcd_pkg::IVL_W-1:0]    interval;
  logic                          end_of_packet;

  modport source (output valid, output interval, output end_of_packet, input ready);
  modport sink   (input valid, input interval, input end_of_packet, output ready);
endinterface

interface bmcd_out_if;
  logic                          valid;
  logic                          ready;
  logic [bmcd_pkg::SYM_W-1:0]    symbol;
  logic                          packet_end;
  logic [bmcd_pkg::STATUS_W-1:0] status;
  logic                          overflow;

  modport source (output valid, output symbol, output packet_end, output status,
                  output overflow, input ready);
  modport sink   (input valid, input symbol, input packet_end, input status,
                  input overflow, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/bmcd_front.sv -----
// ----------------------------------------------------------------------------
// bmcd_front
// Holds the window registers, accepts intervals and classifies them into
// bit 0, bit 1 or nothing, pairing half-bit intervals.
// ----------------------------------------------------------------------------
`default_nettype none

module bmcd_front (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [bmcd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bmcd_pkg::CFG_W-1:0]     cfg_data,
  bmcd_in_if.sink                             din,
  input  wire logic                           q_full,
  output      logic                           push,
  output      bmcd_pkg::evt_t                 evt
);
  import bmcd_pkg::*;

  logic [CFG_W-1:0] full_min;
  logic [CFG_W-1:0] full_max;
  logic [CFG_W-1:0] half_min;
  logic [CFG_W-1:0] half_max;
  logic             half_pending;
  logic             half_pending_next;
  logic             xfer;
  logic             is_full;
  logic             is_half;

  always_ff @(posedge clk) begin
    if (rst) begin
      full_min <= FULL_MIN_RST;
      full_max <= FULL_MAX_RST;
      half_min <= HALF_MIN_RST;
      half_max <= HALF_MAX_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_FULL_MIN: full_min <= cfg_data;
        REG_FULL_MAX: full_max <= cfg_data;
        REG_HALF_MIN: half_min <= cfg_data;
        REG_HALF_MAX: half_max <= cfg_data;
        default: ;
      endcase
    end
  end

  assign din.ready = !q_full;
  assign xfer      = din.valid && !q_full;

  always_comb begin
    is_full = (din.interval >= full_min) && (din.interval <= full_max);
    is_half = (din.interval >= half_min) && (din.interval <= half_max);
    half_pending_next = 1'b0;
    evt.bit_valid = 1'b0;
    evt.bit_value = 1'b0;
    evt.eop       = din.end_of_packet;
    if (din.interval == '0) begin
      half_pending_next = 1'b0;
    end else if (is_full) begin
      evt.bit_valid = 1'b1;
    end else if (is_half) begin
      if (half_pending) begin
        evt.bit_valid = 1'b1;
        evt.bit_value = 1'b1;
      end else begin
        half_pending_next = 1'b1;
      end
    end
    // a half still waiting at the end of a packet is dropped
    if (din.end_of_packet) begin
      half_pending_next = 1'b0;
    end
    push = xfer && (evt.bit_valid || evt.eop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half_pending <= 1'b0;
    end else if (xfer) begin
      half_pending <= half_pending_next;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/bmcd_queue.sv -----
// ----------------------------------------------------------------------------
// bmcd_queue
// Small FIFO of classified events between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module bmcd_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire bmcd_pkg::evt_t push_evt,
  input  wire logic           pop,
  output      bmcd_pkg::evt_t head,
  output      logic           empty,
  output      logic           full
);
  import bmcd_pkg::*;

  evt_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign empty   = (count == '0);
  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_evt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/bmcd_back.sv -----
// ----------------------------------------------------------------------------
// bmcd_back
// Packet state: preamble check, symbol assembly, bit cap and end records.
// Drives the registered result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module bmcd_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire bmcd_pkg::evt_t head,
  input  wire logic           empty,
  output      logic           pop,
  bmcd_out_if.source          dout
);
  import bmcd_pkg::*;

  logic [TOTAL_W-1:0]  bit_total;
  logic [TOTAL_W-1:0]  bit_total_next;
  logic                previous_bit;
  logic                previous_bit_next;
  logic                alt_broken;
  logic                alt_broken_next;
  logic [SYM_W-1:0]    symbol_shift;
  logic [SYM_W-1:0]    symbol_shift_next;
  logic [FILL_W-1:0]   symbol_fill;
  logic [FILL_W-1:0]   symbol_fill_next;
  logic                cap_reached;
  logic                cap_reached_next;

  logic                slot_free;
  logic                take;
  logic                sym_done;
  logic [SYM_W-1:0]    sym_val;
  status_t             status_next;

  // end record held back while a symbol from the same item is out
  logic                end_pend;
  status_t             pend_status;
  logic                pend_ovf;

  logic                out_valid;
  logic [SYM_W-1:0]    out_symbol;
  logic                out_end;
  status_t             out_status;
  logic                out_ovf;

  assign slot_free = !out_valid || dout.ready;
  assign pop       = !empty && slot_free && !end_pend;

  always_comb begin
    take              = pop && head.bit_valid && !cap_reached;
    alt_broken_next   = alt_broken;
    symbol_shift_next = symbol_shift;
    symbol_fill_next  = symbol_fill;
    previous_bit_next = previous_bit;
    bit_total_next    = bit_total;
    cap_reached_next  = cap_reached;
    sym_done          = 1'b0;
    sym_val           = symbol_shift | (SYM_W'(head.bit_value) << symbol_fill);
    if (take) begin
      if (bit_total != '0 && bit_total < TOTAL_W'(PREAMBLE_BITS) &&
          head.bit_value == previous_bit) begin
        alt_broken_next = 1'b1;
      end
      if (bit_total >= TOTAL_W'(PREAMBLE_BITS)) begin
        if (symbol_fill == FILL_W'(SYMBOL_BITS - 1)) begin
          sym_done          = 1'b1;
          symbol_shift_next = '0;
          symbol_fill_next  = '0;
        end else begin
          symbol_shift_next = sym_val;
          symbol_fill_next  = symbol_fill + 1'b1;
        end
      end
      previous_bit_next = head.bit_value;
      bit_total_next    = bit_total + 1'b1;
      if (bit_total == TOTAL_W'(MAX_BITS - 1)) begin
        cap_reached_next = 1'b1;
      end
    end
    if (alt_broken_next) begin
      status_next = ST_NO_PREAMBLE;
    end else if (bit_total_next < TOTAL_W'(PREAMBLE_BITS)) begin
      status_next = ST_TOO_SHORT;
    end else begin
      status_next = ST_OK;
    end
  end

  // packet state
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_total    <= '0;
      previous_bit <= 1'b0;
      alt_broken   <= 1'b0;
      symbol_shift <= '0;
      symbol_fill  <= '0;
      cap_reached  <= 1'b0;
    end else if (pop) begin
      if (head.eop) begin
        bit_total    <= '0;
        previous_bit <= 1'b0;
        alt_broken   <= 1'b0;
        symbol_shift <= '0;
        symbol_fill  <= '0;
        cap_reached  <= 1'b0;
      end else begin
        bit_total    <= bit_total_next;
        previous_bit <= previous_bit_next;
        alt_broken   <= alt_broken_next;
        symbol_shift <= symbol_shift_next;
        symbol_fill  <= symbol_fill_next;
        cap_reached  <= cap_reached_next;
      end
    end
  end

  // output register and deferred end record
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      end_pend  <= 1'b0;
    end else if (slot_free) begin
      if (end_pend) begin
        out_valid <= 1'b1;
        end_pend  <= 1'b0;
      end else if (pop && (sym_done || head.eop)) begin
        out_valid <= 1'b1;
        end_pend  <= sym_done && head.eop;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free) begin
      if (end_pend) begin
        out_symbol <= '0;
        out_end    <= 1'b1;
        out_status <= pend_status;
        out_ovf    <= pend_ovf;
      end else if (pop) begin
        out_ovf <= cap_reached_next;
        if (sym_done) begin
          out_symbol <= sym_val;
          out_end    <= 1'b0;
          out_status <= ST_OK;
        end else begin
          out_symbol <= '0;
          out_end    <= 1'b1;
          out_status <= status_next;
        end
      end
    end
    if (pop) begin
      pend_status <= status_next;
      pend_ovf    <= cap_reached_next;
    end
  end

  assign dout.valid      = out_valid;
  assign dout.symbol     = out_symbol;
  assign dout.packet_end = out_end;
  assign dout.status     = out_status;
  assign dout.overflow   = out_ovf;

endmodule

`default_nettype wire

// ----- hw/rtl/bmc_interval_decoder.sv -----
// ----------------------------------------------------------------------------
// bmc_interval_decoder
// Biphase-mark decoder: edge intervals in, 5-bit symbols and end records out.
// ----------------------------------------------------------------------------
// Path: the queue is written at the input transfer and the back end loads the
//   result register when it pops the item, which waits while the output stalls.
// Throughput: one interval per cycle unless the queue is full; an item with a
//   symbol and end record uses the output for both, absorbed by a 4-entry queue.
// Reset (rst, synchronous): windows go to 20..40 / 8..19, packet state and the
//   queue are cleared, no result is valid.
`default_nettype none

module bmc_interval_decoder (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [bmcd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bmcd_pkg::CFG_W-1:0]     cfg_data,
  bmcd_in_if.sink                             din,
  bmcd_out_if.source                          dout
);
  import bmcd_pkg::*;

  evt_t push_evt;
  evt_t head;
  logic push;
  logic pop;
  logic q_empty;
  logic q_full;

  bmcd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .din       (din),
    .q_full    (q_full),
    .push      (push),
    .evt       (push_evt)
  );

  bmcd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_evt (push_evt),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  bmcd_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .empty (q_empty),
    .pop   (pop),
    .dout  (dout)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/bmcd_chk.sv -----
// ----------------------------------------------------------------------------
// bmcd_chk
// Port-level checks on the result channel of the decoder.
// ----------------------------------------------------------------------------
`default_nettype none
`include "bmc_interval_decoder_assert.svh"

module bmcd_chk (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [bmcd_pkg::SYM_W-1:0]    out_symbol,
  input wire logic                          out_packet_end,
  input wire logic [bmcd_pkg::STATUS_W-1:0] out_status,
  input wire logic                          out_overflow
);
  import bmcd_pkg::*;

  `BMCD_ASSERT_IMP(a_end_sym_zero, out_valid && out_packet_end, out_symbol == '0)
  `BMCD_ASSERT_IMP(a_sym_status_ok, out_valid && !out_packet_end, out_status == ST_OK)
  `BMCD_ASSERT_IMP(a_status_code, out_valid, out_status != 2'd3)
  `BMCD_ASSERT_NXT(a_stall_hold, out_valid && !out_ready,
                   out_valid && $stable(out_symbol) && $stable(out_packet_end) &&
                   $stable(out_status) && $stable(out_overflow))
  // overflow cannot drop within a packet: only an end record resets it
  `BMCD_ASSERT_NXT(a_ovf_sticky, out_valid && out_ready && out_overflow && !out_packet_end,
                   !out_valid || out_overflow)

endmodule

bind bmc_interval_decoder bmcd_chk u_bmcd_chk (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (dout.valid),
  .out_ready      (dout.ready),
  .out_symbol     (dout.symbol),
  .out_packet_end (dout.packet_end),
  .out_status     (dout.status),
  .out_overflow   (dout.overflow)
);

`default_nettype wire

// ----- verif/bmcd_symbol_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bmcd_symbol_checker
// Watches the interval and result channels of the biphase-mark decoder and
// the register write port. Keeps its own copy of the windows and the packet
// state, predicts the symbols and end records of every interval transfer,
// and compares them in order against the result transfers.
// ----------------------------------------------------------------------------

module bmcd_symbol_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [bmcd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bmcd_pkg::CFG_W-1:0]     cfg_data,
  bmcd_in_if                             din,
  bmcd_out_if                            dout,
  output int                             mismatches,
  output int                             outstanding
);
  import bmcd_pkg::*;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             packet_end;
    status_t          status;
    logic             overflow;
  } dec_result_t;

  // window registers
  logic [CFG_W-1:0] full_lo, full_hi, half_lo, half_hi;

  // packet state
  logic             half_wait;
  int unsigned      bits_seen;
  logic             last_bit;
  logic             alt_broken;
  logic [SYM_W-1:0] sym_acc;
  int unsigned      sym_cnt;
  logic             capped;

  dec_result_t pending_results[$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  function automatic void clear_packet();
    half_wait  = 1'b0;
    bits_seen  = 0;
    last_bit   = 1'b0;
    alt_broken = 1'b0;
    sym_acc    = '0;
    sym_cnt    = 0;
    capped     = 1'b0;
  endfunction

  // Shifts one decoded bit in; returns 1 when it completes a symbol.
  function automatic logic shift_bit(input logic b, output logic [SYM_W-1:0] sym);
    logic done;
    done = 1'b0;
    sym  = '0;
    if (bits_seen > 0 && bits_seen < PREAMBLE_BITS && b == last_bit)
      alt_broken = 1'b1;
    if (bits_seen >= PREAMBLE_BITS) begin
      sym_acc[sym_cnt] = b;
      sym_cnt++;
      if (sym_cnt >= SYMBOL_BITS) begin
        sym     = sym_acc;
        sym_acc = '0;
        sym_cnt = 0;
        done    = 1'b1;
      end
    end
    last_bit = b;
    bits_seen++;
    if (bits_seen >= MAX_BITS) begin
      bits_seen = MAX_BITS;
      capped    = 1'b1;
    end
    return done;
  endfunction

  function automatic void decode_interval(input logic [IVL_W-1:0] ivl, input logic eop);
    logic [SYM_W-1:0] sym;
    status_t          st;
    if (!capped) begin
      if (ivl == '0) begin
        half_wait = 1'b0;
      end else if (ivl >= full_lo && ivl <= full_hi) begin
        half_wait = 1'b0;
        if (shift_bit(1'b0, sym))
          pending_results.push_back('{symbol: sym, packet_end: 1'b0, status: ST_OK,
                                      overflow: capped});
      end else if (ivl >= half_lo && ivl <= half_hi) begin
        if (half_wait) begin
          half_wait = 1'b0;
          if (shift_bit(1'b1, sym))
            pending_results.push_back('{symbol: sym, packet_end: 1'b0, status: ST_OK,
                                        overflow: capped});
        end else begin
          half_wait = 1'b1;
        end
      end else begin
        half_wait = 1'b0;
      end
    end
    if (eop) begin
      if (alt_broken)
        st = ST_NO_PREAMBLE;
      else if (bits_seen < PREAMBLE_BITS)
        st = ST_TOO_SHORT;
      else
        st = ST_OK;
      pending_results.push_back('{symbol: '0, packet_end: 1'b1, status: st,
                                  overflow: capped});
      clear_packet();
    end
  endfunction

  always @(posedge clk) begin
    dec_result_t got, want;
    if (rst) begin
      full_lo = FULL_MIN_RST;
      full_hi = FULL_MAX_RST;
      half_lo = HALF_MIN_RST;
      half_hi = HALF_MAX_RST;
      clear_packet();
      pending_results.delete();
    end else begin
      // results can only stem from earlier transfers, so check them first
      if (dout.valid && dout.ready) begin
        got = '{symbol: dout.symbol, packet_end: dout.packet_end,
                status: status_t'(dout.status), overflow: dout.overflow};
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: %0t: result with none expected: sym=%0d end=%0b st=%0d ovf=%0b",
                     $realtime, got.symbol, got.packet_end, got.status, got.overflow);
        end else begin
          want = pending_results.pop_front();
          if (got.symbol !== want.symbol || got.packet_end !== want.packet_end ||
              got.status !== want.status || got.overflow !== want.overflow) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: %0t: expected sym=%0d end=%0b st=%0d ovf=%0b,",
                       $realtime, want.symbol, want.packet_end, want.status, want.overflow,
                       " got sym=%0d end=%0b st=%0d ovf=%0b",
                       got.symbol, got.packet_end, got.status, got.overflow);
          end
        end
      end
      if (din.valid && din.ready)
        decode_interval(din.interval, din.end_of_packet);
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_FULL_MIN: full_lo = cfg_data;
          REG_FULL_MAX: full_hi = cfg_data;
          REG_HALF_MIN: half_lo = cfg_data;
          REG_HALF_MAX: half_hi = cfg_data;
          default: ;
        endcase
      end
    end
    outstanding <= pending_results.size();
  end

endmodule

// ----- verif/tb_bmc_interval_decoder.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bmc_interval_decoder
// Drives edge intervals into the biphase-mark decoder: a directed opening on
// the window edges and dropped-half cases, one packet that runs into the bit
// cap, then random packets (mostly clean preamble plus payload, some short or
// noisy) under several window settings. The checker judges every result.
// ----------------------------------------------------------------------------

module tb_bmc_interval_decoder;
  import bmcd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEM_TARGET = 1250;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  cfg_reg_t         cfg_index;
  logic [CFG_W-1:0] cfg_data;

  bmcd_in_if  ivl_ch ();
  bmcd_out_if sym_ch ();

  int   mismatches;
  int   outstanding;
  int   cycles = 0;
  int   items_sent = 0;
  int   stall_left = 0;
  logic calm;

  // generator's copy of the windows
  logic [CFG_W-1:0] full_lo, full_hi, half_lo, half_hi;

  bmc_interval_decoder u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .din       (ivl_ch),
    .dout      (sym_ch)
  );

  bmcd_symbol_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .din         (ivl_ch),
    .dout        (sym_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result-side backpressure in random bursts, off while calm
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      sym_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 7) - 1;
      sym_ch.ready <= 1'b0;
    end else begin
      sym_ch.ready <= 1'b1;
    end
  end

  function automatic logic [IVL_W-1:0] full_ivl();
    if (full_lo <= full_hi)
      return IVL_W'($urandom_range(full_hi, full_lo));
    return '0;
  endfunction

  function automatic logic [IVL_W-1:0] half_ivl();
    if (half_lo <= half_hi)
      return IVL_W'($urandom_range(half_hi, half_lo));
    return IVL_W'($urandom_range(1, 255));
  endfunction

  // zero, anything, or a lone half-bit
  function automatic logic [IVL_W-1:0] junk_ivl();
    case ($urandom_range(0, 2))
      0:       return '0;
      1:       return IVL_W'($urandom_range(0, 255));
      default: return half_ivl();
    endcase
  endfunction

  task automatic send_item(input logic [IVL_W-1:0] ivl, input logic eop);
    if (!calm && $urandom_range(0, 5) == 0) begin
      ivl_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    ivl_ch.valid         <= 1'b1;
    ivl_ch.interval      <= ivl;
    ivl_ch.end_of_packet <= eop;
    @(posedge clk);
    while (!ivl_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // Stop sending, wait for every expected result, then let the pipe empty.
  task automatic settle();
    ivl_ch.valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_windows(input logic [CFG_W-1:0] f_lo, input logic [CFG_W-1:0] f_hi,
                             input logic [CFG_W-1:0] h_lo, input logic [CFG_W-1:0] h_hi);
    full_lo = f_lo;
    full_hi = f_hi;
    half_lo = h_lo;
    half_hi = h_hi;
    cfg_we    <= 1'b1;
    cfg_index <= REG_FULL_MIN;
    cfg_data  <= f_lo;
    @(posedge clk);
    cfg_index <= REG_FULL_MAX;
    cfg_data  <= f_hi;
    @(posedge clk);
    cfg_index <= REG_HALF_MIN;
    cfg_data  <= h_lo;
    @(posedge clk);
    cfg_index <= REG_HALF_MAX;
    cfg_data  <= h_hi;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Alternating preamble, then random payload; noise flips bits or adds junk.
  task automatic send_packet(input int nbits, input int noise_pct, input int ones_pct);
    logic [IVL_W-1:0] seq[$];
    logic             b;
    for (int i = 0; i < nbits; i++) begin
      if (i < PREAMBLE_BITS)
        b = i[0];
      else
        b = ($urandom_range(0, 99) < ones_pct);
      if ($urandom_range(0, 99) < noise_pct) begin
        if ($urandom_range(0, 1))
          b = ~b;
        else
          seq.push_back(junk_ivl());
      end
      if (b) begin
        seq.push_back(half_ivl());
        seq.push_back(half_ivl());
      end else begin
        seq.push_back(full_ivl());
      end
    end
    if (seq.size() == 0 || $urandom_range(0, 7) == 0)
      seq.push_back(junk_ivl());
    foreach (seq[k])
      send_item(seq[k], k == seq.size() - 1);
  endtask

  initial begin
    int             phase;
    int             kind;
    logic [CFG_W-1:0] h_lo, h_hi, f_lo, f_hi;

    rst                  = 1'b1;
    cfg_we               = 1'b0;
    cfg_index            = REG_FULL_MIN;
    cfg_data             = '0;
    ivl_ch.valid         = 1'b0;
    ivl_ch.interval      = '0;
    ivl_ch.end_of_packet = 1'b0;
    sym_ch.ready         = 1'b0;
    calm                 = 1'b0;
    full_lo              = FULL_MIN_RST;
    full_hi              = FULL_MAX_RST;
    half_lo              = HALF_MIN_RST;
    half_hi              = HALF_MAX_RST;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // window edges, repeated zero breaks preamble, dropped halves
    send_item(8'd20, 1'b0);
    send_item(8'd40, 1'b0);
    send_item(8'd8, 1'b0);
    send_item(8'd19, 1'b0);
    send_item(8'd0, 1'b0);
    send_item(8'd8, 1'b0);
    send_item(8'd0, 1'b0);
    send_item(8'd19, 1'b0);
    send_item(8'd30, 1'b0);
    send_item(8'd255, 1'b0);
    send_item(8'd1, 1'b0);
    send_item(8'd7, 1'b0);
    send_item(8'd41, 1'b0);
    send_item(8'd12, 1'b1);   // lone half on the end transfer
    // short but alternating
    send_item(8'd25, 1'b0);
    send_item(8'd10, 1'b0);
    send_item(8'd15, 1'b1);
    // empty packet
    send_item(8'd0, 1'b1);

    // one packet running past the bit cap
    settle();
    set_windows(FULL_MIN_RST, FULL_MAX_RST, HALF_MIN_RST, HALF_MAX_RST);
    send_packet(MAX_BITS + 8, 0, 10);

    phase = 0;
    while (items_sent < ITEM_TARGET || phase < 6) begin
      settle();
      // last phases run without idling on either side
      if (phase >= 4)
        calm <= 1'b1;
      case (phase)
        0: set_windows(FULL_MIN_RST, FULL_MAX_RST, HALF_MIN_RST, HALF_MAX_RST);
        1: set_windows(8'd1, 8'd255, 8'd1, 8'd255);     // everything is a zero
        2: set_windows(8'd255, 8'd1, 8'd1, 8'd255);     // empty full window
        3: set_windows(8'd255, 8'd255, 8'd1, 8'd254);
        4: set_windows(8'd30, 8'd90, 8'd200, 8'd100);   // empty half window
        5: set_windows(8'd10, 8'd30, 8'd5, 8'd25);      // overlapping windows
        default: begin
          h_lo = CFG_W'($urandom_range(1, 60));
          h_hi = CFG_W'(h_lo + $urandom_range(0, 40));
          f_lo = CFG_W'(h_hi + 1 + $urandom_range(0, 10));
          f_hi = (int'(f_lo) + 120 > 255) ? 8'd255 : CFG_W'(f_lo + $urandom_range(0, 120));
          set_windows(f_lo, f_hi, h_lo, h_hi);
        end
      endcase
      kind = $urandom_range(0, 9);
      if (kind < 6)
        send_packet(PREAMBLE_BITS + $urandom_range(0, 20), $urandom_range(0, 1) * 2, 50);
      else if (kind < 8)
        send_packet($urandom_range(0, PREAMBLE_BITS - 1), 5, 50);
      else
        send_packet(PREAMBLE_BITS + $urandom_range(0, 20), 25, 50);
      phase++;
    end

    settle();
    @(negedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/bmcd_pkg.sv
hw/rtl/bmcd_if.sv
hw/rtl/bmcd_front.sv
hw/rtl/bmcd_queue.sv
hw/rtl/bmcd_back.sv
hw/rtl/bmc_interval_decoder.sv
hw/rtl/bmcd_chk.sv
verif/bmcd_symbol_checker.sv
verif/tb_bmc_interval_decoder.sv
